// ----- src/prs_pkg.sv -----
// Shared types, constants and CORDIC angle table for pose running statistics.
// No dependencies.
`timescale 1ns / 1ps
package prs_pkg;

	localparam int STEP_W       = 6;
	localparam int CORDIC_STEPS = 16;
	localparam int DIV_STEPS    = 62;
	localparam int SQRT_STEPS   = 32;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032875;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_ROT,
		OP_ACC,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_SAVE,
		OP_MSQ,
		OP_VAR,
		OP_SQRT_STEP,
		OP_SQRT_SAVE,
		OP_VEC_INIT,
		OP_VEC_STEP,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [STEP_W-1:0] step;
		logic [1:0]        sel;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} stat_t;

	// atan(2^-i) in units of 2^-24 turn
	function automatic logic signed [25:0] atan_lut(input logic [3:0] i);
		logic signed [25:0] v;
		unique case (i)
			4'd0:  v = 26'sd2097152;
			4'd1:  v = 26'sd1238021;
			4'd2:  v = 26'sd654136;
			4'd3:  v = 26'sd332050;
			4'd4:  v = 26'sd166669;
			4'd5:  v = 26'sd83416;
			4'd6:  v = 26'sd41718;
			4'd7:  v = 26'sd20860;
			4'd8:  v = 26'sd10430;
			4'd9:  v = 26'sd5215;
			4'd10: v = 26'sd2608;
			4'd11: v = 26'sd1304;
			4'd12: v = 26'sd652;
			4'd13: v = 26'sd326;
			4'd14: v = 26'sd163;
			default: v = 26'sd81;
		endcase
		return v;
	endfunction

endpackage

// ----- src/prs_if.sv -----
// Valid/ready channel interfaces for pose samples and statistics results.
// No dependencies.
`timescale 1ns / 1ps
interface prs_sample_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] sample_x;
	logic signed [23:0] sample_y;
	logic [15:0]        sample_angle;

	modport source(output valid, sample_x, sample_y, sample_angle, input ready);
	modport sink(input valid, sample_x, sample_y, sample_angle, output ready);
endinterface

interface prs_result_if;
	logic               valid;
	logic               ready;
	logic [16:0]        sample_count;
	logic signed [23:0] mean_x;
	logic signed [23:0] mean_y;
	logic [23:0]        dev_x;
	logic [23:0]        dev_y;
	logic [15:0]        mean_angle;
	logic               full_res;

	modport source(output valid, sample_count, mean_x, mean_y, dev_x, dev_y, mean_angle,
		full_res, input ready);
	modport sink(input valid, sample_count, mean_x, mean_y, dev_x, dev_y, mean_angle,
		full_res, output ready);
endinterface

// ----- src/prs_ctrl.sv -----
// Sequencer for pose running statistics: issues datapath commands per sample.
// Depends on prs_pkg.
`timescale 1ns / 1ps
module prs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output prs_pkg::cmd_t  cmd,
	input  prs_pkg::stat_t stat
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROT,
		S_ACC,
		S_DIV_INIT,
		S_DIV,
		S_DIV_SAVE,
		S_MSQ,
		S_VAR,
		S_SQRT,
		S_SQRT_SAVE,
		S_VEC_INIT,
		S_VEC,
		S_DONE
	} state_t;

	state_t                     state_q;
	logic [prs_pkg::STEP_W-1:0] step_q;
	logic [1:0]                 sel_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.step = step_q;
		cmd.sel  = sel_q;
		unique case (state_q)
			S_IDLE:      cmd.op = in_valid ? prs_pkg::OP_LOAD : prs_pkg::OP_NONE;
			S_ROT:       cmd.op = prs_pkg::OP_ROT;
			S_ACC:       cmd.op = prs_pkg::OP_ACC;
			S_DIV_INIT:  cmd.op = prs_pkg::OP_DIV_INIT;
			S_DIV:       cmd.op = prs_pkg::OP_DIV_STEP;
			S_DIV_SAVE:  cmd.op = prs_pkg::OP_DIV_SAVE;
			S_MSQ:       cmd.op = prs_pkg::OP_MSQ;
			S_VAR:       cmd.op = prs_pkg::OP_VAR;
			S_SQRT:      cmd.op = prs_pkg::OP_SQRT_STEP;
			S_SQRT_SAVE: cmd.op = prs_pkg::OP_SQRT_SAVE;
			S_VEC_INIT:  cmd.op = prs_pkg::OP_VEC_INIT;
			S_VEC:       cmd.op = prs_pkg::OP_VEC_STEP;
			S_DONE:      cmd.op = stat.out_busy ? prs_pkg::OP_NONE : prs_pkg::OP_OUT;
			default:     cmd.op = prs_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			sel_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ROT;
						step_q  <= '0;
					end
				end
				S_ROT: begin
					step_q <= step_q + 1'b1;
					if (step_q == prs_pkg::STEP_W'(prs_pkg::CORDIC_STEPS - 1)) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					sel_q   <= '0;
					state_q <= S_DIV_INIT;
				end
				S_DIV_INIT: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == prs_pkg::STEP_W'(prs_pkg::DIV_STEPS - 1)) begin
						state_q <= S_DIV_SAVE;
					end
				end
				S_DIV_SAVE: begin
					sel_q <= sel_q + 1'b1;
					if (sel_q == 2'd3) begin
						state_q <= S_MSQ;
					end else begin
						state_q <= S_DIV_INIT;
					end
				end
				S_MSQ: begin
					state_q <= S_VAR;
				end
				S_VAR: begin
					step_q  <= prs_pkg::STEP_W'(prs_pkg::SQRT_STEPS - 1);
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= S_SQRT_SAVE;
					end
				end
				S_SQRT_SAVE: begin
					if (sel_q[0]) begin
						state_q <= S_VEC_INIT;
					end else begin
						sel_q   <= 2'd1;
						state_q <= S_MSQ;
					end
				end
				S_VEC_INIT: begin
					step_q  <= '0;
					state_q <= S_VEC;
				end
				S_VEC: begin
					step_q <= step_q + 1'b1;
					if (step_q == prs_pkg::STEP_W'(prs_pkg::CORDIC_STEPS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!stat.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- src/prs_dp.sv -----
// Datapath: accumulators, CORDIC unit, shared divider, square root and result register.
// Depends on prs_pkg.
`timescale 1ns / 1ps
module prs_dp #(
	parameter int MAX_SAMPLES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  prs_pkg::cmd_t      cmd,
	output prs_pkg::stat_t     stat,
	input  logic signed [23:0] in_x,
	input  logic signed [23:0] in_y,
	input  logic [15:0]        in_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [16:0]        out_count,
	output logic signed [23:0] out_mean_x,
	output logic signed [23:0] out_mean_y,
	output logic [23:0]        out_dev_x,
	output logic [23:0]        out_dev_y,
	output logic [15:0]        out_angle,
	output logic               out_full
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
		logic signed [33:0] t;
		t = (v + 34'sd16384) >>> 15;
		if (t > 34'sd32767) begin
			return 16'sd32767;
		end else if (t < -34'sd32767) begin
			return -16'sd32767;
		end
		return t[15:0];
	endfunction

	logic [CNT_W-1:0]   count_q;
	logic [39:0]        sum_x_q, sum_y_q;
	logic [61:0]        ssq_x_q, ssq_y_q;
	logic [31:0]        ssin_q, scos_q;
	logic               full_q;
	logic signed [23:0] x_q, y_q;
	logic [47:0]        sqx_q, sqy_q;
	logic signed [33:0] rx_q, ry_q;
	logic signed [25:0] rz_q;
	logic [1:0]         quad_q;
	logic [61:0]        div_n_q;
	logic [CNT_W-1:0]   div_r_q;
	logic               div_neg_q;
	logic [23:0]        mean_x_q, mean_y_q;
	logic [30:0]        am_x_q, am_y_q;
	logic [61:0]        qs_x_q, qs_y_q;
	logic [61:0]        msq_q;
	logic [61:0]        sq_v_q;
	logic [62:0]        sq_res_q;
	logic [23:0]        dev_x_q, dev_y_q;
	logic signed [51:0] vx_q, vy_q;
	logic signed [25:0] vz_q;
	logic               vzero_q;
	logic               out_valid_q;

	logic [3:0]         sh;
	logic signed [25:0] at;
	logic signed [33:0] rdx, rdy;
	logic signed [51:0] vdx, vdy;
	logic signed [15:0] qc, qs, cs, sn;
	logic [15:0]        ared, rres;
	logic [1:0]         quad;
	logic [CNT_W:0]     dtrial, dsub;
	logic               dge;
	logic [39:0]        dsum;
	logic [61:0]        qv;
	logic [30:0]        am;
	logic [62:0]        sbit, strial;
	logic signed [51:0] cx, sy;
	logic signed [25:0] vround;

	assign sh   = cmd.step[3:0];
	assign at   = prs_pkg::atan_lut(sh);
	assign rdx  = rx_q >>> sh;
	assign rdy  = ry_q >>> sh;
	assign vdx  = vx_q >>> sh;
	assign vdy  = vy_q >>> sh;

	assign ared = in_angle + 16'd8192;
	assign quad = ared[15:14];
	assign rres = in_angle - {quad, 14'd0};

	assign qc = to_q15(rx_q);
	assign qs = to_q15(ry_q);
	always_comb begin
		unique case (quad_q)
			2'd0: begin cs = qc;  sn = qs;  end
			2'd1: begin cs = -qs; sn = qc;  end
			2'd2: begin cs = -qc; sn = -qs; end
			default: begin cs = qs; sn = -qc; end
		endcase
	end

	assign dtrial = {div_r_q, div_n_q[61]};
	assign dge    = dtrial >= {1'b0, count_q};
	assign dsub   = dtrial - {1'b0, count_q};
	assign dsum   = cmd.sel[0] ? sum_y_q : sum_x_q;

	assign qv     = cmd.sel[0] ? qs_y_q : qs_x_q;
	assign am     = cmd.sel[0] ? am_y_q : am_x_q;
	assign sbit   = 63'd1 << {cmd.step[4:0], 1'b0};
	assign strial = sq_res_q + sbit;

	assign cx     = {{4{scos_q[31]}}, scos_q, 16'd0};
	assign sy     = {{4{ssin_q[31]}}, ssin_q, 16'd0};
	assign vround = vz_q + 26'sd128;

	assign stat.out_busy = out_valid_q;
	assign out_valid     = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			ssq_x_q     <= '0;
			ssq_y_q     <= '0;
			ssin_q      <= '0;
			scos_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				prs_pkg::OP_ACC: begin
					if (count_q < CNT_W'(MAX_SAMPLES)) begin
						count_q <= count_q + CNT_W'(1);
						sum_x_q <= sum_x_q + {{16{x_q[23]}}, x_q};
						sum_y_q <= sum_y_q + {{16{y_q[23]}}, y_q};
						ssq_x_q <= ssq_x_q + {14'd0, sqx_q};
						ssq_y_q <= ssq_y_q + {14'd0, sqy_q};
						ssin_q  <= ssin_q + {{16{sn[15]}}, sn};
						scos_q  <= scos_q + {{16{cs[15]}}, cs};
					end
				end
				prs_pkg::OP_OUT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			prs_pkg::OP_LOAD: begin
				x_q    <= in_x;
				y_q    <= in_y;
				sqx_q  <= 48'(in_x * in_x);
				sqy_q  <= 48'(in_y * in_y);
				quad_q <= quad;
				rx_q   <= prs_pkg::CORDIC_X0;
				ry_q   <= '0;
				rz_q   <= {{2{rres[15]}}, rres, 8'd0};
			end
			prs_pkg::OP_ROT: begin
				if (rz_q >= 0) begin
					rx_q <= rx_q - rdy;
					ry_q <= ry_q + rdx;
					rz_q <= rz_q - at;
				end else begin
					rx_q <= rx_q + rdy;
					ry_q <= ry_q - rdx;
					rz_q <= rz_q + at;
				end
			end
			prs_pkg::OP_ACC: begin
				full_q <= count_q >= CNT_W'(MAX_SAMPLES);
			end
			prs_pkg::OP_DIV_INIT: begin
				div_r_q <= '0;
				unique case (cmd.sel)
					2'd2: begin div_n_q <= ssq_x_q; div_neg_q <= 1'b0; end
					2'd3: begin div_n_q <= ssq_y_q; div_neg_q <= 1'b0; end
					default: begin
						div_neg_q <= dsum[39];
						div_n_q   <= {22'd0, dsum[39] ? 40'd0 - dsum : dsum};
					end
				endcase
			end
			prs_pkg::OP_DIV_STEP: begin
				div_r_q <= dge ? dsub[CNT_W-1:0] : dtrial[CNT_W-1:0];
				div_n_q <= {div_n_q[60:0], dge};
			end
			prs_pkg::OP_DIV_SAVE: begin
				unique case (cmd.sel)
					2'd0: begin
						mean_x_q <= div_neg_q ? 24'd0 - div_n_q[23:0] : div_n_q[23:0];
						am_x_q   <= div_n_q[30:0];
					end
					2'd1: begin
						mean_y_q <= div_neg_q ? 24'd0 - div_n_q[23:0] : div_n_q[23:0];
						am_y_q   <= div_n_q[30:0];
					end
					2'd2: qs_x_q <= div_n_q;
					default: qs_y_q <= div_n_q;
				endcase
			end
			prs_pkg::OP_MSQ: begin
				msq_q <= {31'd0, am} * {31'd0, am};
			end
			prs_pkg::OP_VAR: begin
				sq_v_q   <= (qv >= msq_q) ? qv - msq_q : '0;
				sq_res_q <= '0;
			end
			prs_pkg::OP_SQRT_STEP: begin
				if ({1'b0, sq_v_q} >= strial) begin
					sq_v_q   <= sq_v_q - strial[61:0];
					sq_res_q <= (sq_res_q >> 1) + sbit;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
			end
			prs_pkg::OP_SQRT_SAVE: begin
				if (cmd.sel[0]) begin
					dev_y_q <= sq_res_q[23:0];
				end else begin
					dev_x_q <= sq_res_q[23:0];
				end
			end
			prs_pkg::OP_VEC_INIT: begin
				vzero_q <= (scos_q == '0) && (ssin_q == '0);
				if (scos_q[31]) begin
					vx_q <= -cx;
					vy_q <= -sy;
					vz_q <= 26'sd8388608;
				end else begin
					vx_q <= cx;
					vy_q <= sy;
					vz_q <= '0;
				end
			end
			prs_pkg::OP_VEC_STEP: begin
				if (vy_q >= 0) begin
					vx_q <= vx_q + vdy;
					vy_q <= vy_q - vdx;
					vz_q <= vz_q + at;
				end else begin
					vx_q <= vx_q - vdy;
					vy_q <= vy_q + vdx;
					vz_q <= vz_q - at;
				end
			end
			prs_pkg::OP_OUT: begin
				out_count  <= 17'(count_q);
				out_mean_x <= mean_x_q;
				out_mean_y <= mean_y_q;
				out_dev_x  <= dev_x_q;
				out_dev_y  <= dev_y_q;
				out_angle  <= vzero_q ? 16'd0 : vround[23:8];
				out_full   <= full_q;
			end
			default: ;
		endcase
	end

endmodule

// ----- src/pose_running_statistics.sv -----
// Pose running statistics, one sample at a time, from sample beat to result:
// 16 CORDIC rotations, four 62-step divisions on one shared divider, two 32-step
// square roots and 16 CORDIC vectoring steps. A new sample is taken while the
// previous result beat still waits. Reset clears count and all sums at once.
// Depends on prs_pkg, prs_if, prs_ctrl, prs_dp.
`timescale 1ns / 1ps
module pose_running_statistics #(
	parameter int MAX_SAMPLES = 65536
) (
	input logic          clk,
	input logic          arst_n,
	prs_sample_if.sink   sample,
	prs_result_if.source result
);

	prs_pkg::cmd_t  cmd;
	prs_pkg::stat_t stat;

	prs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	prs_dp #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_x       (sample.sample_x),
		.in_y       (sample.sample_y),
		.in_angle   (sample.sample_angle),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_count  (result.sample_count),
		.out_mean_x (result.mean_x),
		.out_mean_y (result.mean_y),
		.out_dev_x  (result.dev_x),
		.out_dev_y  (result.dev_y),
		.out_angle  (result.mean_angle),
		.out_full   (result.full_res)
	);

endmodule
